// ===== hdl/gmt_pkg.sv =====
// ---------------------------------------------------------------------------
// gmt_pkg
// Shared types and codes for the group membership table: status codes,
// command kinds and the command record passed from front end to back end.
// ---------------------------------------------------------------------------
package gmt_pkg;

    // Field widths of the stream items
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int LEN_W    = 13;
    localparam int CAP_W    = 7;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    // Operation codes on the input stream
    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOOLONG  = 3'd4;

    // Command kinds after classification
    localparam logic [1:0] K_SINGLE = 2'd0;  // one result, status already known
    localparam logic [1:0] K_ADD    = 2'd1;
    localparam logic [1:0] K_REMOVE = 2'd2;
    localparam logic [1:0] K_STREAM = 2'd3;  // walk the table, one result per member

    typedef struct packed {
        logic [1:0]          kind;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     member_id;
        logic [CAP_W-1:0]    target_cap;
    } cmd_t;

endpackage

// ===== hdl/group_membership_table_unit.sv =====
// ---------------------------------------------------------------------------
// group_membership_table_unit
// Multicast group table: add, remove and dispatch over a fixed set of slots.
// ---------------------------------------------------------------------------
// Usage:
//   Items on the s_ stream carry operation, member id, payload length and
//   target cap; each yields one or more m_ results, the final one with
//   m_tlast. The cfg_ channel writes the broadcast enable; write it only
//   while the block is idle.
//   A two-entry command queue decouples the front end from the back end.
//   Single-result items: the result passes the queue entry and the output
//   register; one per cycle while m_tready is high. Add and remove pass
//   queue pop, id compare and table update before the next item is taken.
//   Dispatch: the walk skips each empty slot and, for each active member,
//   reads its id from the RAM copy and then emits its result.
//   Reset empties the table and disables broadcast; no clearing pass. A low
//   m_tready holds the output register, the back end waits, the queue fills
//   and s_tready drops.
// ---------------------------------------------------------------------------
module group_membership_table_unit #(
    parameter int SLOTS      = 64,
    parameter int MAX_LENGTH = 4096,
    parameter int ID_WIDTH   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: broadcast_enable
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], member_id[17:2],
                                   // payload_length[30:18], target_cap[37:31]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[2:0], target_id[18:3],
                                   // total_targets[25:19]
    output logic        m_tuser,   // target_valid[0]
    output logic        m_tlast
);

    localparam int ID_BITS = (ID_WIDTH < gmt_pkg::ID_W) ? ID_WIDTH : gmt_pkg::ID_W;

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_not_empty;
    gmt_pkg::cmd_t q_cmd;
    gmt_pkg::cmd_t q_head;

    gmt_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    gmt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    gmt_back #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== hdl/gmt_ram.sv =====
// ---------------------------------------------------------------------------
// gmt_ram
// Generic single-write, single-read RAM with registered read data. The read
// register only updates on a read enable, so data holds until the next read.
// ---------------------------------------------------------------------------
module gmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/gmt_front.sv =====
// ---------------------------------------------------------------------------
// gmt_front
// Front end: holds the broadcast enable, accepts input items and classifies
// them into commands. Items whose result needs no table access are resolved
// here to a single-result command carrying its status.
// ---------------------------------------------------------------------------
module gmt_front #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,
    // command queue
    input  logic                       q_full,
    output logic                       q_push,
    output gmt_pkg::cmd_t              q_cmd
);

    localparam int CMP_W = 17;

    logic                            enable_reg;
    logic                            enable_next;
    logic [gmt_pkg::OP_W-1:0]        op;
    logic [gmt_pkg::LEN_W-1:0]       len;
    logic                            too_long;

    // Broadcast enable register
    assign cfg_ready   = 1'b1;
    assign enable_next = (cfg_valid) ? cfg_data : enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else begin
            enable_reg <= enable_next;
        end
    end

    // Field unpack
    assign op       = s_tdata[1:0];
    assign len      = s_tdata[30:18];
    assign too_long = CMP_W'(len) > CMP_W'(MAX_LENGTH);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classification
    always_comb begin
        q_cmd            = '0;
        q_cmd.member_id  = s_tdata[17:2];
        q_cmd.target_cap = s_tdata[37:31];
        q_cmd.status     = gmt_pkg::ST_OK;
        case (op)
            gmt_pkg::OP_ADD: begin
                q_cmd.kind = gmt_pkg::K_ADD;
            end
            gmt_pkg::OP_REMOVE: begin
                q_cmd.kind = gmt_pkg::K_REMOVE;
            end
            gmt_pkg::OP_DISPATCH: begin
                if (too_long) begin
                    q_cmd.kind   = gmt_pkg::K_SINGLE;
                    q_cmd.status = gmt_pkg::ST_TOOLONG;
                end else if (!enable_reg || len == '0) begin
                    q_cmd.kind = gmt_pkg::K_SINGLE;
                end else begin
                    q_cmd.kind = gmt_pkg::K_STREAM;
                end
            end
            default: begin
                // unused opcode: plain ok result
                q_cmd.kind = gmt_pkg::K_SINGLE;
            end
        endcase
    end

endmodule

// ===== hdl/gmt_queue.sv =====
// ---------------------------------------------------------------------------
// gmt_queue
// Two-entry command queue between front end and back end.
// ---------------------------------------------------------------------------
module gmt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gmt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output gmt_pkg::cmd_t head
);

    gmt_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/gmt_back.sv =====
// ---------------------------------------------------------------------------
// gmt_back
// Back end: owns the membership table and carries out commands. Add and
// remove use a registered parallel id compare; dispatch walks the slots in
// order, reading ids from a RAM copy, and feeds the output register.
// ---------------------------------------------------------------------------
module gmt_back #(
    parameter int SLOTS   = 64,
    parameter int ID_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // command queue
    input  logic                              q_not_empty,
    input  gmt_pkg::cmd_t                     q_head,
    output logic                              q_pop,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int CMP_W = (CW > gmt_pkg::CAP_W) ? CW : gmt_pkg::CAP_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_RES  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]                    state_reg, state_next;
    gmt_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [SLOTS-1:0]              active_reg;
    logic [ID_BITS-1:0]            ids_reg [SLOTS];
    logic [SLOTS-1:0]              match_reg, match_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 sent_reg, sent_next;
    logic [IW-1:0]                 idx_reg, idx_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [gmt_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic                          m_user_reg, m_user_next;
    logic [gmt_pkg::ID_W-1:0]      m_id_reg, m_id_next;
    logic [gmt_pkg::TOTAL_W-1:0]   m_total_reg, m_total_next;
    logic                          m_last_reg, m_last_next;
    logic                          out_free;

    // table update controls
    logic                          tbl_set, tbl_clr;
    logic [IW-1:0]                 tbl_slot;
    logic [ID_BITS-1:0]            cmd_id;
    logic [IW-1:0]                 open_slot, hit_slot;
    logic                          rd_en;
    logic [ID_BITS-1:0]            rd_data;
    logic [CW-1:0]                 sent_inc;
    logic                          is_last;

    assign out_free = !m_valid_reg || m_tready;
    assign cmd_id   = cmd_reg.member_id[ID_BITS-1:0];
    assign sent_inc = sent_reg + CW'(1);
    assign is_last  = (sent_inc == count_reg);

    // Lowest free slot and lowest matching slot
    always_comb begin
        open_slot = '0;
        hit_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                open_slot = IW'(i);
            end
            if (match_reg[i]) begin
                hit_slot = IW'(i);
            end
        end
    end

    // Parallel compare of the command id against every slot
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_next[i] = active_reg[i] && (ids_reg[i] == cmd_id);
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        sent_next     = sent_reg;
        idx_next      = idx_reg;
        q_pop         = 1'b0;
        tbl_set       = 1'b0;
        tbl_clr       = 1'b0;
        tbl_slot      = open_slot;
        rd_en         = 1'b0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_user_next   = m_user_reg;
        m_id_next     = m_id_reg;
        m_total_next  = m_total_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_not_empty && out_free) begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    case (q_head.kind)
                        gmt_pkg::K_ADD, gmt_pkg::K_REMOVE: begin
                            state_next = S_CMP;
                        end
                        gmt_pkg::K_STREAM: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = gmt_pkg::ST_OK;
                                m_user_next   = 1'b0;
                                m_id_next     = '0;
                                m_total_next  = '0;
                                m_last_next   = 1'b1;
                            end else begin
                                idx_next   = '0;
                                sent_next  = '0;
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            m_valid_next  = 1'b1;
                            m_status_next = q_head.status;
                            m_user_next   = 1'b0;
                            m_id_next     = '0;
                            m_total_next  = '0;
                            m_last_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP: begin
                state_next = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_user_next   = 1'b0;
                    m_id_next     = '0;
                    m_total_next  = '0;
                    m_last_next   = 1'b1;
                    m_status_next = gmt_pkg::ST_OK;
                    state_next    = S_IDLE;
                    if (cmd_reg.kind == gmt_pkg::K_ADD) begin
                        if (|match_reg) begin
                            m_status_next = gmt_pkg::ST_DUP;
                        end else if (&active_reg) begin
                            m_status_next = gmt_pkg::ST_FULL;
                        end else begin
                            tbl_set    = 1'b1;
                            tbl_slot   = open_slot;
                            count_next = count_reg + CW'(1);
                        end
                    end else begin
                        if (!(|match_reg)) begin
                            m_status_next = gmt_pkg::ST_NOTFOUND;
                        end else begin
                            tbl_clr  = 1'b1;
                            tbl_slot = hit_slot;
                            if (count_reg != '0) begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                end
            end
            S_RD: begin
                // skip empty slots, fetch the id of an active one
                if (active_reg[idx_reg]) begin
                    rd_en      = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = gmt_pkg::ST_OK;
                    m_user_next   = CMP_W'(sent_reg) < CMP_W'(cmd_reg.target_cap);
                    m_id_next     = gmt_pkg::ID_W'(rd_data);
                    m_total_next  = is_last ? gmt_pkg::TOTAL_W'(sent_inc) : '0;
                    m_last_next   = is_last;
                    sent_next     = sent_inc;
                    idx_next      = idx_reg + IW'(1);
                    state_next    = is_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (tbl_set) begin
                active_reg[tbl_slot] <= 1'b1;
            end else if (tbl_clr) begin
                active_reg[tbl_slot] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        match_reg    <= match_next;
        sent_reg     <= sent_next;
        idx_reg      <= idx_next;
        m_status_reg <= m_status_next;
        m_user_reg   <= m_user_next;
        m_id_reg     <= m_id_next;
        m_total_reg  <= m_total_next;
        m_last_reg   <= m_last_next;
        if (tbl_set) begin
            ids_reg[tbl_slot] <= cmd_id;
        end
    end

    // Id copy for the dispatch walk
    gmt_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_id_ram (
        .aclk    (aclk),
        .wr_en   (tbl_set),
        .wr_addr (tbl_slot),
        .wr_data (cmd_id),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_total_reg, m_id_reg, m_status_reg};
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
